/* design/assert_macros.svh */
// Assertion helpers shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BFPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication into the next cycle outside reset.
`define BFPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bfpa_pkg.sv */
`default_nettype none
package bfpa_pkg;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // Search record that travels down the row of cells
  typedef struct packed {
    logic        vld;
    logic        found;
    logic [15:0] req;
    logic [15:0] best_left;
  } search_t;

  // Update command broadcast to the cells
  typedef struct packed {
    logic        wr_en;
    logic        mark_en;
    logic [15:0] wr_size;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/bfpa_in_if.sv */
`default_nettype none
interface bfpa_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] size;

  modport source (output valid, output cmd, output size, input ready);
  modport sink   (input valid, input cmd, input size, output ready);
endinterface
`default_nettype wire

/* design/bfpa_out_if.sv */
`default_nettype none
interface bfpa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  block_index;
  logic [15:0] fragment;
  logic [15:0] unpartitioned;

  modport source (output valid, output status, output block_index, output fragment,
                  output unpartitioned, input ready);
  modport sink   (input valid, input status, input block_index, input fragment,
                  input unpartitioned, output ready);
endinterface
`default_nettype wire

/* design/bfpa_cell.sv */
`default_nettype none
`include "assert_macros.svh"
module bfpa_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfpa_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]     ctrl_idx,
  input  bfpa_pkg::search_t    sin,
  input  logic [IDX_W-1:0]     sin_idx,
  output bfpa_pkg::search_t    sout,
  output logic [IDX_W-1:0]     sout_idx
);
  import bfpa_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [15:0]      size_r;
  logic             valid_r;
  logic             used_r;
  search_t          sout_r;
  logic [IDX_W-1:0] idx_r;

  logic             hit;
  logic [16:0]      diff;
  logic             take;

  assign hit  = (ctrl_idx == MY_IDX);
  assign diff = {1'b0, size_r} - {1'b0, sin.req};

  // Take the record over when this partition is free, fits and leaves strictly less
  assign take = sin.vld && valid_r && !used_r && !diff[16] &&
                (!sin.found || (diff[15:0] < sin.best_left));

  // Hold partition size; written once when the partition is added
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && hit) begin
      size_r <= ctrl.wr_size;
    end
  end

  // Track valid and used flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      used_r  <= 1'b0;
    end else if (ctrl.wr_en && hit) begin
      valid_r <= 1'b1;
      used_r  <= 1'b0;
    end else if (ctrl.mark_en && hit) begin
      used_r  <= 1'b1;
    end
  end

  // Advance the search record one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sout_r.vld <= 1'b0;
    end else begin
      sout_r.vld <= sin.vld;
    end
    sout_r.req <= sin.req;
    if (take) begin
      sout_r.found     <= 1'b1;
      sout_r.best_left <= diff[15:0];
      idx_r            <= MY_IDX;
    end else begin
      sout_r.found     <= sin.found;
      sout_r.best_left <= sin.best_left;
      idx_r            <= sin_idx;
    end
  end

  assign sout     = sout_r;
  assign sout_idx = idx_r;

  `BFPA_ASSERT_NEXT(a_cell_pass, sin.vld, sout.vld, "search record lost in cell")

endmodule
`default_nettype wire

/* design/best_fit_partition_allocator_core.sv */
// Best-fit fixed-partition allocator. Write total_memory through cfg_we/cfg_wdata while
// the block is idle. An add command (cmd 0) carves a partition of the given size from the
// unpartitioned memory; it is refused when it does not fit or the table is full, and
// every add after a refusal is refused too until reset. An allocate command (cmd 1)
// sends a search record down a row of MAX_PARTITIONS cells, one cell per cycle,
// and marks the unused partition with the least leftover (lowest index on a tie). An
// allocate result is captured when the search record leaves the end of the row, so the row
// length sets the allocate latency. One command is in flight at a time; a new command is
// taken while the previous result still waits in the output register.
`default_nettype none
`include "assert_macros.svh"
module best_fit_partition_allocator_core #(
  parameter int MAX_PARTITIONS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  bfpa_in_if.sink      in_ch,
  bfpa_out_if.source   out_ch
);
  import bfpa_pkg::*;

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTITIONS);

  state_t           state_r;
  logic [15:0]      total_r;
  logic [15:0]      carved_r;
  logic [CNT_W-1:0] count_r;
  logic             closed_r;
  logic             launch_r;
  logic [15:0]      req_r;
  logic [1:0]       res_status_r;
  logic [IDX_W-1:0] res_idx_r;
  logic [15:0]      res_frag_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [3:0]       out_idx_r;
  logic [15:0]      out_frag_r;
  logic [15:0]      out_unpart_r;

  search_t          chain    [MAX_PARTITIONS+1];
  logic [IDX_W-1:0] idx_chain[MAX_PARTITIONS+1];
  cell_ctrl_t       ctrl;
  logic [IDX_W-1:0] ctrl_idx;

  logic             accept;
  logic [15:0]      free_space;
  logic             add_refuse;
  logic             out_free;
  search_t          tail;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W+3:0] res_idx_ext;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign free_space = (total_r >= carved_r) ? (total_r - carved_r) : 16'd0;
  assign add_refuse = closed_r || (count_r >= CNT_MAX) || (in_ch.size > free_space);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign tail       = chain[MAX_PARTITIONS];
  assign tail_idx   = idx_chain[MAX_PARTITIONS];
  assign res_idx_ext = {4'd0, res_idx_r};

  // Inject the search record at the head of the row
  assign chain[0].vld       = launch_r;
  assign chain[0].found     = 1'b0;
  assign chain[0].req       = req_r;
  assign chain[0].best_left = 16'd0;
  assign idx_chain[0]       = '0;

  // Broadcast add and mark commands to the cells
  assign ctrl.wr_en   = accept && (in_ch.cmd == CMD_ADD) && !add_refuse;
  assign ctrl.mark_en = tail.vld && tail.found;
  assign ctrl.wr_size = in_ch.size;
  assign ctrl_idx     = ctrl.wr_en ? count_r[IDX_W-1:0] : tail_idx;

  for (genvar k = 0; k < MAX_PARTITIONS; k++) begin : g_cell
    bfpa_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .ctrl_idx (ctrl_idx),
      .sin      (chain[k]),
      .sin_idx  (idx_chain[k]),
      .sout     (chain[k+1]),
      .sout_idx (idx_chain[k+1])
    );
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 16'd0;
    end else if (cfg_we) begin
      total_r <= cfg_wdata;
    end
  end

  // Sequence one command at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      carved_r <= 16'd0;
      count_r  <= '0;
      closed_r <= 1'b0;
      launch_r <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.cmd == CMD_ALLOC) begin
              launch_r <= 1'b1;
              state_r  <= ST_SCAN;
            end else begin
              if (add_refuse) begin
                closed_r <= 1'b1;
              end else begin
                count_r  <= count_r + CNT_W'(1);
                carved_r <= carved_r + in_ch.size;
              end
              state_r <= ST_HOLD;
            end
          end
        end
        ST_SCAN: begin
          if (tail.vld) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Capture the request and the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_ch.size;
      if (in_ch.cmd == CMD_ADD) begin
        res_status_r <= add_refuse ? STAT_REFUSED : STAT_OK;
        res_idx_r    <= add_refuse ? '0 : count_r[IDX_W-1:0];
        res_frag_r   <= 16'd0;
      end
    end else if ((state_r == ST_SCAN) && tail.vld) begin
      res_status_r <= tail.found ? STAT_OK : STAT_NOFIT;
      res_idx_r    <= tail.found ? tail_idx : '0;
      res_frag_r   <= tail.found ? tail.best_left : 16'd0;
    end
  end

  // Move the pending result into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_HOLD) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_HOLD) && out_free) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_ext[3:0];
      out_frag_r   <= res_frag_r;
      out_unpart_r <= free_space;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.block_index   = out_idx_r;
  assign out_ch.fragment      = out_frag_r;
  assign out_ch.unpartitioned = out_unpart_r;

  `BFPA_ASSERT(a_tail_in_scan, !tail.vld || (state_r == ST_SCAN),
               "search result arrived outside a scan")
  `BFPA_ASSERT(a_count_bound, count_r <= CNT_MAX, "partition count beyond table size")
  `BFPA_ASSERT_NEXT(a_refuse_closes, accept && (in_ch.cmd == CMD_ADD) && add_refuse,
                    closed_r, "refused add did not close further adds")

endmodule
`default_nettype wire
